// File: hdl/dq_pkg.sv
// Shared types and constants for the double-ended queue.
`timescale 1ns / 1ps
package dq_pkg;

  localparam int WORD_W = 32;
  localparam int OCC_W  = 5;

  typedef enum logic [1:0] {
    CMD_PUSH_REAR  = 2'd0,
    CMD_PUSH_FRONT = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_REAR   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  localparam logic signed [WORD_W-1:0] NO_VALUE = '1;

  // Per-cell control for one cycle.
  typedef struct packed {
    logic load;   // take the pushed word
    logic shr;    // take the word of the cell toward the front
    logic shl;    // take the word of the cell toward the rear
    logic rear;   // this cell holds the rear entry
  } cell_ctl_t;

endpackage

// File: hdl/dq_req_if.sv
// Request channel: command and push word.
`timescale 1ns / 1ps
interface dq_req_if;
  import dq_pkg::*;

  logic                     valid;
  logic                     ready;
  cmd_t                     cmd;
  logic signed [WORD_W-1:0] push_value;

  modport source (output valid, output cmd, output push_value, input ready);
  modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

// File: hdl/dq_rsp_if.sv
// Response channel: popped word, status and occupancy.
`timescale 1ns / 1ps
interface dq_rsp_if;
  import dq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] pop_value;
  status_t                  status;
  logic [OCC_W-1:0]         occupancy;

  modport source (output valid, output pop_value, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input pop_value, input status, input occupancy,
                  output ready);
endinterface

// File: hdl/double_ended_queue_core.sv
// Top level of the double-ended queue: a row of cells with the front at cell 0.
//
//   channel  dir  handshake          payload
//   req      in   valid/ready        cmd, push_value
//   rsp      out  valid/ready        pop_value, status, occupancy
//
// One request per cycle; the response register takes its response in the next cycle.
// Throughput is set by the response register: a new request is taken whenever it is
// empty or being drained in the same cycle, so a stalled response stalls requests.
// Push front and pop front shift the whole row by one cell; push rear writes only the
// cell at the count, pop rear reads the one before. Synchronous reset empties the queue.
`timescale 1ns / 1ps
module double_ended_queue_core #(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  dq_req_if.sink    req,
  dq_rsp_if.source  rsp
);
  import dq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic                     fire;
  logic                     is_push;
  logic                     full;
  logic                     empty;
  logic                     ok;
  logic signed [WORD_W-1:0] cell_data [DEPTH];
  logic signed [WORD_W-1:0] cell_rear [DEPTH];
  cell_ctl_t                cell_ctl  [DEPTH];
  logic signed [WORD_W-1:0] rear_word;
  logic signed [WORD_W-1:0] result_value;
  status_t                  result_status;

  logic                     rsp_valid;
  logic signed [WORD_W-1:0] rsp_value;
  status_t                  rsp_status;
  logic [OCC_W-1:0]         rsp_occ;

  assign req.ready = !rsp_valid || rsp.ready;
  assign fire      = req.valid && req.ready;
  assign is_push   = (req.cmd == CMD_PUSH_REAR) || (req.cmd == CMD_PUSH_FRONT);
  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign ok        = is_push ? !full : !empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [WORD_W-1:0] front_in;
    logic signed [WORD_W-1:0] rear_in;

    if (i == 0) begin : g_first
      assign front_in = cell_data[0];
    end else begin : g_mid
      assign front_in = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rear_in = cell_data[i];
    end else begin : g_inner
      assign rear_in = cell_data[i+1];
    end

    always_comb begin
      cell_ctl[i].load = fire && ok &&
                         (((req.cmd == CMD_PUSH_REAR) && (count == CNT_W'(i))) ||
                          ((req.cmd == CMD_PUSH_FRONT) && (i == 0)));
      cell_ctl[i].shr  = fire && ok && (req.cmd == CMD_PUSH_FRONT) && (i != 0);
      cell_ctl[i].shl  = fire && ok && (req.cmd == CMD_POP_FRONT);
      cell_ctl[i].rear = (count == CNT_W'(i + 1));
    end

    dq_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[i]),
      .push_value (req.push_value),
      .from_front (front_in),
      .from_rear  (rear_in),
      .data       (cell_data[i]),
      .rear_data  (cell_rear[i])
    );
  end

  always_comb begin
    rear_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_word = rear_word | cell_rear[i];
    end
  end

  always_comb begin
    result_value  = NO_VALUE;
    result_status = ST_OK;
    count_next    = count;
    if (!ok) begin
      result_status = is_push ? ST_FULL : ST_EMPTY;
    end else begin
      unique case (req.cmd)
        CMD_PUSH_REAR, CMD_PUSH_FRONT: count_next = count + CNT_W'(1);
        CMD_POP_FRONT: begin
          result_value = cell_data[0];
          count_next   = count - CNT_W'(1);
        end
        CMD_POP_REAR: begin
          result_value = rear_word;
          count_next   = count - CNT_W'(1);
        end
        default: count_next = count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (fire) begin
        count <= count_next;
      end
      if (fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_value  <= result_value;
      rsp_status <= result_status;
      rsp_occ    <= OCC_W'(count_next);
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.pop_value = rsp_value;
  assign rsp.status    = rsp_status;
  assign rsp.occupancy = rsp_occ;

endmodule

// File: hdl/dq_cell.sv
// One storage cell of the queue row: holds a word and trades it with its neighbors.
`timescale 1ns / 1ps
module dq_cell (
  input  logic                             clk,
  input  dq_pkg::cell_ctl_t                ctl,
  input  logic signed [dq_pkg::WORD_W-1:0] push_value,
  input  logic signed [dq_pkg::WORD_W-1:0] from_front,
  input  logic signed [dq_pkg::WORD_W-1:0] from_rear,
  output logic signed [dq_pkg::WORD_W-1:0] data,
  output logic signed [dq_pkg::WORD_W-1:0] rear_data
);
  import dq_pkg::*;

  logic signed [WORD_W-1:0] data_next;

  always_comb begin
    priority if (ctl.load) begin
      data_next = push_value;
    end else if (ctl.shr) begin
      data_next = from_front;
    end else if (ctl.shl) begin
      data_next = from_rear;
    end else begin
      data_next = data;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // Zero unless this cell is the rear, so the row can be OR-reduced.
  assign rear_data = ctl.rear ? data : '0;

endmodule

// File: hdl/dq_checker.sv
// Port-level checks for the double-ended queue, bound to the top level.
`timescale 1ns / 1ps
module dq_checker #(
  parameter int DEPTH = 16
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             req_valid,
  input logic                             req_ready,
  input logic                             rsp_valid,
  input logic                             rsp_ready,
  input logic signed [dq_pkg::WORD_W-1:0] rsp_pop_value,
  input dq_pkg::status_t                  rsp_status,
  input logic [dq_pkg::OCC_W-1:0]         rsp_occupancy
);
  import dq_pkg::*;

  // A refused push only happens with every cell held.
  a_full_occ : assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp_status == ST_FULL)) |-> (rsp_occupancy == OCC_W'(DEPTH)))
    else $error("full status with queue not full");

  // A refused pop reports an empty queue and no word.
  a_empty_occ : assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp_status == ST_EMPTY)) |->
      ((rsp_occupancy == '0) && (rsp_pop_value == NO_VALUE)))
    else $error("empty status with entries held or a word returned");

  // Every accepted request gives a response in the next cycle.
  a_req_to_rsp : assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> rsp_valid)
    else $error("accepted request produced no response");

  // A stalled response holds.
  a_rsp_hold : assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_pop_value) && $stable(rsp_status) &&
       $stable(rsp_occupancy)))
    else $error("stalled response changed");

endmodule

bind double_ended_queue_core dq_checker #(.DEPTH(DEPTH)) u_dq_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_pop_value (rsp.pop_value),
  .rsp_status    (rsp.status),
  .rsp_occupancy (rsp.occupancy)
);

// File: test/tb.sv
// Self-checking testbench for the double-ended queue core.
`timescale 1ns / 1ps
module tb;
  import dq_pkg::*;

  localparam int QUEUE_DEPTH  = 16;
  localparam int HOLD_CYCLES  = 60;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_PRINTED  = 20;
  localparam int WALK_BLOCKS  = 35;
  localparam int BLOCK_ITEMS  = 50;

  typedef struct {
    logic signed [WORD_W-1:0] pop_value;
    status_t                  status;
    logic [OCC_W-1:0]         occupancy;
  } deque_result_t;

  logic clk;
  logic rst;

  dq_req_if req_ch ();
  dq_rsp_if rsp_ch ();

  double_ended_queue_core #(
    .DEPTH(QUEUE_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Shadow copy of the queue: ring of words, front index and count.
  logic signed [WORD_W-1:0] shadow_ring [QUEUE_DEPTH];
  int front_idx;
  int held_count;

  deque_result_t expected_results [$];
  int error_count = 0;
  int idle_cycles = 0;
  bit gaps_on = 1'b1;
  bit hold_request = 1'b0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic deque_result_t apply_deque_op(cmd_t op, logic signed [WORD_W-1:0] word);
    deque_result_t r;
    r.pop_value = NO_VALUE;
    r.status = ST_OK;
    case (op)
      CMD_PUSH_REAR, CMD_PUSH_FRONT: begin
        if (held_count >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else if (op == CMD_PUSH_REAR) begin
          shadow_ring[(front_idx + held_count) % QUEUE_DEPTH] = word;
          held_count++;
        end else begin
          front_idx = (front_idx + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
          shadow_ring[front_idx] = word;
          held_count++;
        end
      end
      default: begin
        if (held_count == 0) begin
          r.status = ST_EMPTY;
        end else if (op == CMD_POP_FRONT) begin
          r.pop_value = shadow_ring[front_idx];
          front_idx = (front_idx + 1) % QUEUE_DEPTH;
          held_count--;
        end else begin
          r.pop_value = shadow_ring[(front_idx + held_count - 1) % QUEUE_DEPTH];
          held_count--;
        end
      end
    endcase
    r.occupancy = OCC_W'(held_count);
    return r;
  endfunction

  function automatic logic signed [WORD_W-1:0] random_word();
    logic signed [WORD_W-1:0] w;
    case ($urandom_range(0, 7))
      0: w = {1'b1, {(WORD_W-1){1'b0}}};
      1: w = {1'b0, {(WORD_W-1){1'b1}}};
      2: w = '1;
      3: w = '0;
      default: w = $urandom;
    endcase
    return w;
  endfunction

  function automatic cmd_t random_cmd(int push_pct);
    cmd_t op;
    if ($urandom_range(0, 99) < push_pct) begin
      op = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
    end else begin
      op = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_REAR;
    end
    return op;
  endfunction

  task automatic report_mismatch(string field, logic [WORD_W-1:0] got,
                                 logic [WORD_W-1:0] want);
    error_count++;
    if (error_count <= MAX_PRINTED) begin
      $display("%0t ns: %s mismatch: got %h, expected %h", $time, field, got, want);
    end
  endtask

  // Drive one request at the falling edge; predict once it is taken.
  task automatic send_request(cmd_t op, logic signed [WORD_W-1:0] word);
    int gap;
    gap = gaps_on ? $urandom_range(0, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.cmd        <= op;
    req_ch.push_value <= word;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    expected_results.push_back(apply_deque_op(op, word));
  endtask

  task automatic test_refusals_and_last_entry();
    send_request(CMD_POP_FRONT, 32'h1234_5678);
    send_request(CMD_POP_REAR, random_word());
    send_request(CMD_PUSH_REAR, 32'h7FFF_FFFF);
    send_request(CMD_POP_REAR, random_word());
    send_request(CMD_PUSH_FRONT, 32'h8000_0000);
    send_request(CMD_POP_FRONT, random_word());
    send_request(CMD_PUSH_FRONT, '1);
    send_request(CMD_POP_REAR, '0);
  endtask

  task automatic test_fill_to_full();
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      case (i % 4)
        0: send_request(CMD_PUSH_REAR, 32'h5555_5555);
        1: send_request(CMD_PUSH_FRONT, 32'hAAAA_AAAA);
        2: send_request(CMD_PUSH_FRONT, random_word());
        default: send_request(CMD_PUSH_REAR, random_word());
      endcase
    end
    send_request(CMD_PUSH_REAR, 32'h0BAD_F00D);
    send_request(CMD_PUSH_FRONT, 32'hF00D_0BAD);
  endtask

  // Drain the full queue from both ends and past empty, then push again; the output side first holds off.
  task automatic test_output_hold_off();
    gaps_on = 1'b0;
    hold_request = 1'b1;
    for (int i = 0; i < QUEUE_DEPTH + 4; i++) begin
      send_request($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_REAR, random_word());
    end
    for (int i = 0; i < 4; i++) begin
      send_request(random_cmd(100), random_word());
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_random_walk();
    int push_pct;
    for (int b = 0; b < WALK_BLOCKS; b++) begin
      case ($urandom_range(0, 2))
        0: push_pct = 15;
        1: push_pct = 50;
        default: push_pct = 85;
      endcase
      gaps_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < BLOCK_ITEMS; i++) begin
        send_request(random_cmd(push_pct), random_word());
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin : response_drain
    int gap;
    rsp_ch.ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (hold_request) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        gap = gaps_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
          rsp_ch.ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    deque_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unrequested response", rsp_ch.pop_value, '0);
      end else begin
        want = expected_results.pop_front();
        if (rsp_ch.pop_value !== want.pop_value) begin
          report_mismatch("pop_value", rsp_ch.pop_value, want.pop_value);
        end
        if (rsp_ch.status !== want.status) begin
          report_mismatch("status", WORD_W'(rsp_ch.status), WORD_W'(want.status));
        end
        if (rsp_ch.occupancy !== want.occupancy) begin
          report_mismatch("occupancy", WORD_W'(rsp_ch.occupancy), WORD_W'(want.occupancy));
        end
      end
    end
  end

  // Abort when neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    req_ch.valid      = 1'b0;
    req_ch.cmd        = CMD_PUSH_REAR;
    req_ch.push_value = '0;
    front_idx  = 0;
    held_count = 0;
    rst = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_refusals_and_last_entry();
    test_fill_to_full();
    test_output_hold_off();
    test_random_walk();

    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
